// ===== design/fault_coalescing_table_unit_defines.svh =====
// Assertion macros shared by the fault coalescing table modules.
`ifndef FAULT_COALESCING_TABLE_UNIT_DEFINES_SVH
`define FAULT_COALESCING_TABLE_UNIT_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define FCT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define FCT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/fct_pkg.sv =====
// Types and constants for the fault coalescing table.
`timescale 1ns / 1ps
package fct_pkg;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned CODE_W  = 16;
  localparam int unsigned SRC_W   = 8;
  localparam int unsigned TRIG_W  = 16;
  localparam int unsigned LIMIT_W = 8;
  localparam int unsigned KEY_W   = CODE_W + SRC_W + TRIG_W;
  localparam int unsigned HITS_W  = 32;
  localparam int unsigned HELD_W  = 5;
  localparam int unsigned TALLY_W = 32;

  typedef enum logic [FUNC_W-1:0] {
    FN_REPORT   = 2'd0,
    FN_DRAIN    = 2'd1,
    FN_CLEAR    = 2'd2,
    FN_SNAPSHOT = 2'd3
  } func_e;

  // What every cell of the chain does in a cycle
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_REPORT,
    OP_SHIFT,
    OP_ROTATE
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [HITS_W-1:0]  hits_t;
  typedef logic [TALLY_W-1:0] tally_t;

  // Command broadcast from the controller to all cells
  typedef struct packed {
    cell_op_e op;
    logic     append;
    key_t     key;
  } cell_cmd_t;

endpackage

// ===== design/fct_if.sv =====
// Input and result channel interfaces of the fault coalescing table.
`timescale 1ns / 1ps
interface fct_in_if;
  import fct_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [CODE_W-1:0]    fault_code;
  logic [SRC_W-1:0]     source_id;
  logic [TRIG_W-1:0]    trigger_id;
  logic [LIMIT_W-1:0]   drain_limit;

  modport source (
    output valid, func, fault_code, source_id, trigger_id, drain_limit,
    input  ready
  );
  modport sink (
    input  valid, func, fault_code, source_id, trigger_id, drain_limit,
    output ready
  );
endinterface

interface fct_out_if;
  import fct_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 status;
  logic                 rec_valid;
  logic [CODE_W-1:0]    rec_fault_code;
  logic [SRC_W-1:0]     rec_source_id;
  logic [TRIG_W-1:0]    rec_trigger_id;
  logic [HITS_W-1:0]    rec_hits;
  logic                 last;
  logic [HELD_W-1:0]    entries_held;
  logic [TALLY_W-1:0]   total_reports;
  logic [TALLY_W-1:0]   merged_reports;
  logic [TALLY_W-1:0]   lost_reports;

  modport source (
    output valid, status, rec_valid, rec_fault_code, rec_source_id, rec_trigger_id,
           rec_hits, last, entries_held, total_reports, merged_reports, lost_reports,
    input  ready
  );
  modport sink (
    input  valid, status, rec_valid, rec_fault_code, rec_source_id, rec_trigger_id,
           rec_hits, last, entries_held, total_reports, merged_reports, lost_reports,
    output ready
  );
endinterface

// ===== design/fct_cell.sv =====
// One table cell: holds a fault key and its hit tally, matches and moves them.
`timescale 1ns / 1ps
module fct_cell #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned IDX      = 0,
  localparam int unsigned CntW    = $clog2(CAPACITY + 1)
) (
  input  logic               clk_i,
  input  fct_pkg::cell_cmd_t cmd_i,
  input  logic [CntW-1:0]    count_i,
  input  fct_pkg::key_t      next_key_i,
  input  fct_pkg::hits_t     next_hits_i,
  input  fct_pkg::key_t      head_key_i,
  input  fct_pkg::hits_t     head_hits_i,
  output fct_pkg::key_t      key_o,
  output fct_pkg::hits_t     hits_o,
  output logic               match_o
);
  import fct_pkg::*;

  key_t  key_q, key_d;
  hits_t hits_q, hits_d;
  logic  live;

  // Match the broadcast key against a held entry
  assign live    = CntW'(IDX) < count_i;
  assign match_o = live && (key_q == cmd_i.key);

  // Merge, append, shift forward or rotate through the held entries
  always_comb begin
    key_d  = key_q;
    hits_d = hits_q;
    unique case (cmd_i.op)
      OP_HOLD: begin
      end
      OP_REPORT: begin
        if (match_o) begin
          hits_d = hits_q + 1'b1;
        end else if (cmd_i.append && (count_i == CntW'(IDX))) begin
          key_d  = cmd_i.key;
          hits_d = HITS_W'(1);
        end
      end
      OP_SHIFT: begin
        key_d  = next_key_i;
        hits_d = next_hits_i;
      end
      OP_ROTATE: begin
        if (count_i == CntW'(IDX + 1)) begin
          key_d  = head_key_i;
          hits_d = head_hits_i;
        end else begin
          key_d  = next_key_i;
          hits_d = next_hits_i;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    hits_q <= hits_d;
  end

  assign key_o  = key_q;
  assign hits_o = hits_q;

endmodule

// ===== design/fct_ctrl.sv =====
// Controller: decodes functions, keeps the count and tallies, emits results.
`timescale 1ns / 1ps
`include "fault_coalescing_table_unit_defines.svh"
module fct_ctrl #(
  parameter int unsigned CAPACITY = 16,
  localparam int unsigned CntW    = $clog2(CAPACITY + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  fct_in_if.sink             fault_i,
  fct_out_if.source          result_o,
  input  logic               any_match_i,
  input  fct_pkg::key_t      head_key_i,
  input  fct_pkg::hits_t     head_hits_i,
  output fct_pkg::cell_cmd_t cmd_o,
  output logic [CntW-1:0]    count_o
);
  import fct_pkg::*;

  localparam int unsigned CmpW = (CntW > LIMIT_W) ? CntW : LIMIT_W;

  state_e          state_q, state_d;
  cell_op_e        mode_q, mode_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] remain_q, remain_d;
  tally_t          total_q, total_d;
  tally_t          merged_q, merged_d;
  tally_t          lost_q, lost_d;

  logic            ov_q, ov_d;
  logic            status_q, status_d;
  logic            recv_q, recv_d;
  key_t            rkey_q, rkey_d;
  hits_t           rhits_q, rhits_d;
  logic            last_q, last_d;
  logic            load;

  logic            in_ready;
  logic            in_fire;
  logic            out_free;
  func_e           func;
  key_t            key_in;
  logic [CmpW-1:0] cnt_ext;
  logic [CmpW-1:0] lim_ext;
  logic [CntW-1:0] drain_n;

  assign out_free = !ov_q || result_o.ready;
  assign in_fire  = fault_i.valid && in_ready;
  assign func     = func_e'(fault_i.func);
  assign key_in   = {fault_i.fault_code, fault_i.source_id, fault_i.trigger_id};

  // Clip the drain to the entries held
  assign cnt_ext = CmpW'(count_q);
  assign lim_ext = CmpW'(fault_i.drain_limit);
  assign drain_n = (cnt_ext < lim_ext) ? count_q : CntW'(fault_i.drain_limit);

  // Next state, cell command and result load
  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    count_d    = count_q;
    remain_d   = remain_q;
    total_d    = total_q;
    merged_d   = merged_q;
    lost_d     = lost_q;
    in_ready   = 1'b0;
    cmd_o.op     = OP_HOLD;
    cmd_o.append = 1'b0;
    cmd_o.key    = key_in;
    load       = 1'b0;
    status_d   = 1'b0;
    recv_d     = 1'b0;
    rkey_d     = '0;
    rhits_d    = '0;
    last_d     = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        in_ready = out_free;
        if (in_fire) begin
          load = 1'b1;
          unique case (func)
            FN_REPORT: begin
              cmd_o.op = OP_REPORT;
              total_d  = total_q + 1'b1;
              if (any_match_i) begin
                merged_d = merged_q + 1'b1;
              end else if (count_q == CntW'(CAPACITY)) begin
                lost_d   = lost_q + 1'b1;
                status_d = 1'b1;
              end else begin
                cmd_o.append = 1'b1;
                count_d      = count_q + 1'b1;
              end
            end
            FN_CLEAR: begin
              count_d = '0;
            end
            FN_DRAIN: begin
              if (drain_n != '0) begin
                load     = 1'b0;
                count_d  = count_q - drain_n;
                remain_d = drain_n;
                mode_d   = OP_SHIFT;
                state_d  = ST_EMIT;
              end
            end
            FN_SNAPSHOT: begin
              if (count_q != '0) begin
                load     = 1'b0;
                remain_d = count_q;
                mode_d   = OP_ROTATE;
                state_d  = ST_EMIT;
              end
            end
          endcase
        end
      end
      ST_EMIT: begin
        // Emit the head entry and advance the chain by one
        if (out_free) begin
          load     = 1'b1;
          recv_d   = 1'b1;
          rkey_d   = head_key_i;
          rhits_d  = head_hits_i;
          last_d   = (remain_q == CntW'(1));
          cmd_o.op = mode_q;
          remain_d = remain_q - 1'b1;
          if (remain_q == CntW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
    endcase

    if (load) begin
      ov_d = 1'b1;
    end else if (result_o.ready) begin
      ov_d = 1'b0;
    end else begin
      ov_d = ov_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      mode_q   <= OP_HOLD;
      count_q  <= '0;
      remain_q <= '0;
      total_q  <= '0;
      merged_q <= '0;
      lost_q   <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      count_q  <= count_d;
      remain_q <= remain_d;
      total_q  <= total_d;
      merged_q <= merged_d;
      lost_q   <= lost_d;
      ov_q     <= ov_d;
    end
  end

  // Hold the result payload until taken
  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q <= status_d;
      recv_q   <= recv_d;
      rkey_q   <= rkey_d;
      rhits_q  <= rhits_d;
      last_q   <= last_d;
    end
  end

  assign fault_i.ready          = in_ready;
  assign count_o                = count_q;
  assign result_o.valid          = ov_q;
  assign result_o.status         = status_q;
  assign result_o.rec_valid      = recv_q;
  assign result_o.rec_fault_code = rkey_q[KEY_W-1 -: CODE_W];
  assign result_o.rec_source_id  = rkey_q[TRIG_W +: SRC_W];
  assign result_o.rec_trigger_id = rkey_q[TRIG_W-1:0];
  assign result_o.rec_hits       = rhits_q;
  assign result_o.last           = last_q;
  assign result_o.entries_held   = HELD_W'(count_q);
  assign result_o.total_reports  = total_q;
  assign result_o.merged_reports = merged_q;
  assign result_o.lost_reports   = lost_q;

  `FCT_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CntW'(CAPACITY), "entry count above capacity")
  `FCT_ASSERT_IMP(a_emit_remain, state_q == ST_EMIT, remain_q != '0, "emitting with nothing left")
  `FCT_ASSERT_IMP(a_emit_no_input, state_q == ST_EMIT, !in_ready, "input taken while emitting")
  `FCT_ASSERT_NXT(a_report_result, in_fire && (func == FN_REPORT), ov_q && last_q && !recv_q, "report gave no single result")

endmodule

// ===== design/fault_coalescing_table_unit.sv =====
// Fault coalescing table: a chain of entry cells and their controller.
//
// Keeps up to CAPACITY fault entries, oldest first, each with a 40-bit key and a
// 32-bit hit tally. A report or a clear gives one result; reports can follow each
// other every cycle while results are taken. A drain or snapshot enters an emit
// state and gives one result per emitted entry: the cell chain moves one entry to
// the head per cycle while results are taken (shifting for a drain, rotating for a
// snapshot), and the block takes no new input until the last entry has been emitted.
// Empty drains and snapshots give a single result with no record. Entry storage needs no clearing after reset.
`timescale 1ns / 1ps
`include "fault_coalescing_table_unit_defines.svh"
module fault_coalescing_table_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fct_in_if.sink    fault_i,
  fct_out_if.source result_o
);
  import fct_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  cell_cmd_t             cmd;
  logic [CntW-1:0]       count;
  key_t                  cell_key [CAPACITY];
  hits_t                 cell_hits [CAPACITY];
  logic [CAPACITY-1:0]   match;
  logic                  any_match;

  assign any_match = |match;

  fct_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fault_i     (fault_i),
    .result_o    (result_o),
    .any_match_i (any_match),
    .head_key_i  (cell_key[0]),
    .head_hits_i (cell_hits[0]),
    .cmd_o       (cmd),
    .count_o     (count)
  );

  // Build the cell chain; the tail cell feeds itself
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    key_t  nkey;
    hits_t nhits;
    if (g < CAPACITY - 1) begin : g_mid
      assign nkey  = cell_key[g+1];
      assign nhits = cell_hits[g+1];
    end else begin : g_tail
      assign nkey  = cell_key[g];
      assign nhits = cell_hits[g];
    end

    fct_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (g)
    ) u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .count_i     (count),
      .next_key_i  (nkey),
      .next_hits_i (nhits),
      .head_key_i  (cell_key[0]),
      .head_hits_i (cell_hits[0]),
      .key_o       (cell_key[g]),
      .hits_o      (cell_hits[g]),
      .match_o     (match[g])
    );
  end

  `FCT_ASSERT_IMP(a_unique_keys, fault_i.valid && fault_i.ready, $onehot0(match), "key held in more than one entry")

endmodule

// ===== sim/fct_table_monitor.sv =====
// Monitor for the fault table: tracks the table, predicts every result and counts mismatches.
`timescale 1ns / 1ps
module fct_table_monitor #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fct_in_if           fault_i,
  fct_out_if          result_i,
  output int unsigned pending_o,
  output int unsigned mismatches_o
);
  import fct_pkg::*;

  // One result transaction as it should appear on the result channel
  typedef struct packed {
    logic              status;
    logic              rec_valid;
    logic [CODE_W-1:0] fault_code;
    logic [SRC_W-1:0]  source_id;
    logic [TRIG_W-1:0] trigger_id;
    hits_t             hits;
    logic              last;
    logic [HELD_W-1:0] held;
    tally_t            total;
    tally_t            merged;
    tally_t            lost;
  } fault_result_t;

  // Shadow copy of the table, oldest entry at index 0
  key_t            table_keys[CAPACITY];
  hits_t           table_hits[CAPACITY];
  int unsigned     held_count;
  tally_t          report_count;
  tally_t          merge_count;
  tally_t          loss_count;
  fault_result_t   expected_results[$];
  int unsigned     mismatch_total;

  // Count a mismatch and print it
  task automatic flag_mismatch(input string msg);
    mismatch_total++;
    $display("%0t ns: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
    end
  endtask

  // Append one expected result; record fields are zero without a record
  function automatic void queue_result(input logic status, input logic rec_valid,
                                       input key_t key, input hits_t hits,
                                       input logic last);
    fault_result_t res;
    res.status     = status;
    res.rec_valid  = rec_valid;
    res.fault_code = rec_valid ? key[KEY_W-1 -: CODE_W] : '0;
    res.source_id  = rec_valid ? key[TRIG_W +: SRC_W] : '0;
    res.trigger_id = rec_valid ? key[TRIG_W-1:0] : '0;
    res.hits       = rec_valid ? hits : '0;
    res.last       = last;
    res.held       = HELD_W'(held_count);
    res.total      = report_count;
    res.merged     = merge_count;
    res.lost       = loss_count;
    expected_results.push_back(res);
  endfunction

  // Update the shadow table for one request and queue the results it causes
  function automatic void apply_request(input func_e fn, input key_t key,
                                        input logic [LIMIT_W-1:0] limit);
    int unsigned n;
    logic        matched;
    logic        dropped;
    key_t        out_keys[CAPACITY];
    hits_t       out_hits[CAPACITY];
    matched = 1'b0;
    dropped = 1'b0;
    case (fn)
      FN_REPORT: begin
        report_count++;
        for (int unsigned i = 0; i < held_count; i++) begin
          if (!matched && table_keys[i] == key) begin
            table_hits[i]++;
            merge_count++;
            matched = 1'b1;
          end
        end
        if (!matched) begin
          if (held_count >= CAPACITY) begin
            loss_count++;
            dropped = 1'b1;
          end else begin
            table_keys[held_count] = key;
            table_hits[held_count] = hits_t'(1);
            held_count++;
          end
        end
        queue_result(dropped, 1'b0, '0, '0, 1'b1);
      end
      FN_CLEAR: begin
        held_count = 0;
        queue_result(1'b0, 1'b0, '0, '0, 1'b1);
      end
      FN_SNAPSHOT: begin
        if (held_count == 0) begin
          queue_result(1'b0, 1'b0, '0, '0, 1'b1);
        end
        for (int unsigned i = 0; i < held_count; i++) begin
          queue_result(1'b0, 1'b1, table_keys[i], table_hits[i], i + 1 == held_count);
        end
      end
      default: begin
        // Drain: take the oldest entries, shift the rest forward
        n = (32'(limit) < held_count) ? 32'(limit) : held_count;
        if (n == 0) begin
          queue_result(1'b0, 1'b0, '0, '0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < n; i++) begin
            out_keys[i] = table_keys[i];
            out_hits[i] = table_hits[i];
          end
          for (int unsigned i = 0; i + n < held_count; i++) begin
            table_keys[i] = table_keys[i + n];
            table_hits[i] = table_hits[i + n];
          end
          held_count = held_count - n;
          for (int unsigned i = 0; i < n; i++) begin
            queue_result(1'b0, 1'b1, out_keys[i], out_hits[i], i + 1 == n);
          end
        end
      end
    endcase
  endfunction

  // Compare one result transaction with the oldest expectation
  task automatic check_result();
    fault_result_t want;
    if (expected_results.size() == 0) begin
      flag_mismatch("result transaction with no result expected");
      return;
    end
    want = expected_results.pop_front();
    compare_field("status", 32'(result_i.status), 32'(want.status));
    compare_field("rec_valid", 32'(result_i.rec_valid), 32'(want.rec_valid));
    compare_field("rec_fault_code", 32'(result_i.rec_fault_code), 32'(want.fault_code));
    compare_field("rec_source_id", 32'(result_i.rec_source_id), 32'(want.source_id));
    compare_field("rec_trigger_id", 32'(result_i.rec_trigger_id), 32'(want.trigger_id));
    compare_field("rec_hits", 32'(result_i.rec_hits), 32'(want.hits));
    compare_field("last", 32'(result_i.last), 32'(want.last));
    compare_field("entries_held", 32'(result_i.entries_held), 32'(want.held));
    compare_field("total_reports", 32'(result_i.total_reports), 32'(want.total));
    compare_field("merged_reports", 32'(result_i.merged_reports), 32'(want.merged));
    compare_field("lost_reports", 32'(result_i.lost_reports), 32'(want.lost));
  endtask

  // Sample both channels; requests are applied before results are popped
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count     = 0;
      report_count   = '0;
      merge_count    = '0;
      loss_count     = '0;
      mismatch_total = 0;
      expected_results.delete();
      pending_o    <= 0;
      mismatches_o <= 0;
    end else begin
      if (fault_i.valid && fault_i.ready) begin
        apply_request(func_e'(fault_i.func),
                      {fault_i.fault_code, fault_i.source_id, fault_i.trigger_id},
                      fault_i.drain_limit);
      end
      if (result_i.valid && result_i.ready) begin
        check_result();
      end
      pending_o    <= expected_results.size();
      mismatches_o <= mismatch_total;
    end
  end

endmodule

// ===== sim/tb_fault_coalescing_table_unit.sv =====
// Testbench top for the fault coalescing table: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_fault_coalescing_table_unit;
  import fct_pkg::*;

  localparam int unsigned TABLE_DEPTH     = 16;
  localparam int unsigned POOL_SIZE       = 24;
  localparam int unsigned ITEMS_PER_PHASE = 77;
  localparam int unsigned TAIL_CYCLES     = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned idle_pct  = 22;
  int unsigned stall_pct = 76;
  int unsigned pending_count;
  int unsigned mismatch_count;
  key_t        key_pool[POOL_SIZE];

  fct_in_if  fault_if ();
  fct_out_if result_if ();

  fault_coalescing_table_unit #(
    .CAPACITY (TABLE_DEPTH)
  ) u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fault_i  (fault_if),
    .result_o (result_if)
  );

  fct_table_monitor #(
    .CAPACITY (TABLE_DEPTH)
  ) u_monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fault_i      (fault_if),
    .result_i     (result_if),
    .pending_o    (pending_count),
    .mismatches_o (mismatch_count)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Stall the result channel at the current rate
  initial result_if.ready = 1'b0;
  always @(posedge clk_i) begin
    result_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("fault_coalescing_table_unit verification failed");
    $finish;
  end

  function automatic key_t random_key();
    return key_t'({$urandom, $urandom});
  endfunction

  // Present one request after a random gap and hold it until accepted
  task automatic send_request(input func_e fn, input key_t key,
                              input logic [LIMIT_W-1:0] limit);
    while ($urandom_range(99) < idle_pct) begin
      fault_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    fault_if.valid       <= 1'b1;
    fault_if.func        <= fn;
    fault_if.fault_code  <= key[KEY_W-1 -: CODE_W];
    fault_if.source_id   <= key[TRIG_W +: SRC_W];
    fault_if.trigger_id  <= key[TRIG_W-1:0];
    fault_if.drain_limit <= limit;
    @(posedge clk_i);
    while (!fault_if.ready) @(posedge clk_i);
  endtask

  initial begin
    int unsigned phase_idle[3];
    int unsigned phase_stall[3];
    int unsigned roll;
    key_t        pick_key;
    key_t        seed_key;
    logic [LIMIT_W-1:0] pick_limit;

    phase_idle  = '{22, 76, 0};
    phase_stall = '{76, 22, 0};

    rst_ni               = 1'b0;
    fault_if.valid       <= 1'b0;
    fault_if.func        <= FN_REPORT;
    fault_if.fault_code  <= '0;
    fault_if.source_id   <= '0;
    fault_if.trigger_id  <= '0;
    fault_if.drain_limit <= '0;

    // Distinct keys: all zeros, all ones, then random upper bits over an index
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int unsigned i = 2; i < POOL_SIZE; i++) begin
      seed_key    = random_key();
      key_pool[i] = {seed_key[KEY_W-1:5], 5'(i)};
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extreme keys, merge, empty and zero-limit drains, clear, empty table
    send_request(FN_REPORT, key_pool[0], 8'd0);
    send_request(FN_REPORT, key_pool[1], 8'hff);
    send_request(FN_REPORT, key_pool[1], 8'd3);
    send_request(FN_DRAIN, random_key(), 8'd0);
    send_request(FN_SNAPSHOT, random_key(), LIMIT_W'($urandom_range(255)));
    send_request(FN_DRAIN, random_key(), 8'd1);
    send_request(FN_CLEAR, random_key(), LIMIT_W'($urandom_range(255)));
    send_request(FN_DRAIN, random_key(), 8'hff);
    send_request(FN_SNAPSHOT, random_key(), LIMIT_W'($urandom_range(255)));

    // Fill the table, overflow it, merge while full, then read and drain it all
    for (int unsigned i = 0; i < TABLE_DEPTH; i++) begin
      send_request(FN_REPORT, key_pool[i], LIMIT_W'($urandom_range(255)));
    end
    send_request(FN_REPORT, key_pool[TABLE_DEPTH], LIMIT_W'($urandom_range(255)));
    send_request(FN_REPORT, key_pool[5], LIMIT_W'($urandom_range(255)));
    send_request(FN_SNAPSHOT, random_key(), LIMIT_W'($urandom_range(255)));
    send_request(FN_DRAIN, random_key(), 8'hff);

    // Random: mostly reports from a small key pool so entries merge and the table fills
    for (int unsigned p = 0; p < 3; p++) begin
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
        roll       = $urandom_range(99);
        pick_limit = LIMIT_W'($urandom_range(255));
        if (roll < 62) begin
          pick_key = ($urandom_range(4) == 0) ? random_key()
                                              : key_pool[$urandom_range(POOL_SIZE - 1)];
          send_request(FN_REPORT, pick_key, pick_limit);
        end else if (roll < 80) begin
          if ($urandom_range(9) != 0) begin
            pick_limit = LIMIT_W'($urandom_range(6));
          end
          send_request(FN_DRAIN, random_key(), pick_limit);
        end else if (roll < 84) begin
          send_request(FN_CLEAR, random_key(), pick_limit);
        end else begin
          send_request(FN_SNAPSHOT, random_key(), pick_limit);
        end
      end
    end

    // Wait for every expected result, then let the block settle
    fault_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("fault_coalescing_table_unit verification clean");
    end else begin
      $display("fault_coalescing_table_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== fault_coalescing_table_unit.f =====
+incdir+design
design/fct_pkg.sv
design/fct_if.sv
design/fct_cell.sv
design/fct_ctrl.sv
design/fault_coalescing_table_unit.sv
sim/fct_table_monitor.sv
sim/tb_fault_coalescing_table_unit.sv
